// File: hw/rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rstn, expr, msg)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg)

`endif

`endif

// File: hw/rtl/bii_pkg.sv
// shared constants, types and helpers of the binary integral image core
package bii_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int PIXEL_W   = 8;
    localparam int AREA_W    = 22;
    // row sum spans -MAX_WIDTH..MAX_WIDTH, line values span +-MAX_WIDTH*MAX_HEIGHT
    localparam int ROW_SUM_W = COL_W + 2;
    localparam int LINE_W    = COL_W + ROW_W + 2;

    localparam logic [PIXEL_W-1:0] PIXEL_HIT = 8'd255;

    localparam logic [CFG_W-1:0] CFG_WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] CFG_HEIGHT_RESET = 11'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // control handed from the top level to the line chain
    typedef struct packed {
        logic             shift;
        logic [COL_W-1:0] last_col;
    } line_ctrl_t;

    // zero acts as one, oversize acts as the maximum; returns size minus one
    function automatic logic [COL_W-1:0] last_col_index(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] dec;
        dec = v - 1'b1;
        if (v == '0) begin
            return '0;
        end else if (int'(v) > MAX_WIDTH) begin
            return COL_W'(MAX_WIDTH - 1);
        end else begin
            return dec[COL_W-1:0];
        end
    endfunction

    function automatic logic [ROW_W-1:0] last_row_index(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] dec;
        dec = v - 1'b1;
        if (v == '0) begin
            return '0;
        end else if (int'(v) > MAX_HEIGHT) begin
            return ROW_W'(MAX_HEIGHT - 1);
        end else begin
            return dec[ROW_W-1:0];
        end
    endfunction

endpackage

// File: hw/rtl/bii_cell.sv
// one line-store cell: holds the integral value of one column of the row above
module bii_cell import bii_pkg::*; (
    input  logic                     aclk,
    input  logic                     shift,
    input  logic                     load_sel,
    input  logic signed [LINE_W-1:0] from_next,
    input  logic signed [LINE_W-1:0] insert_data,
    output logic signed [LINE_W-1:0] value
);

    logic signed [LINE_W-1:0] value_reg;
    logic signed [LINE_W-1:0] value_next;

    // the cell at the row end takes the new value, the others take their neighbor
    assign value_next = load_sel ? insert_data : from_next;

    always_ff @(posedge aclk) begin
        if (shift) begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

// File: hw/rtl/bii_line.sv
// line store as a chain of cells shifting toward the head once per pixel
module bii_line import bii_pkg::*; (
    input  logic                     aclk,
    input  line_ctrl_t               ctrl,
    input  logic signed [LINE_W-1:0] insert_data,
    output logic signed [LINE_W-1:0] head
);

    logic signed [LINE_W-1:0] chain [MAX_WIDTH];

    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
        logic signed [LINE_W-1:0] from_next;
        logic                     load_sel;

        if (i == MAX_WIDTH - 1) begin : g_tail
            assign from_next = insert_data;
        end else begin : g_body
            assign from_next = chain[i+1];
        end

        assign load_sel = (ctrl.last_col == COL_W'(i));

        bii_cell u_cell (
            .aclk        (aclk),
            .shift       (ctrl.shift),
            .load_sel    (load_sel),
            .from_next   (from_next),
            .insert_data (insert_data),
            .value       (chain[i])
        );
    end

    assign head = chain[0];

endmodule

// File: hw/rtl/binary_integral_image_core.sv
// top level of the binary integral image core
//
// usage:
//   s_pixel comes in raster order on a valid/ready channel, one transaction
//   per pixel. each pixel maps to +1 when it is exactly 255, else -1.
//   m_area_sum carries the summed-area value from the frame origin to that
//   pixel, m_last_of_frame flags the final pixel of the frame.
//   cfg_wr_en/cfg_index/cfg_data write frame_width (index 0) or frame_height
//   (index 1); any write restarts the frame at row 0, column 0.
//   the result is registered: m_valid rises in the cycle after the input transaction.
//   throughput: one pixel per cycle unless the receiver stalls, set by the single
//   add path from the line-store head through the row sum into the row-end cell.
//   the line store is a chain of MAX_WIDTH cells that all shift once per
//   accepted pixel; the value written at the row end comes back to the
//   head exactly one row later.
//   reset: sizes return to 640 x 480, counters and row sum clear; the line
//   store needs no clearing since the first row never reads it.
//   stall: a waiting result holds while m_ready is low, and s_ready
//   drops only while a result is waiting and the receiver is stalled.
`include "assert_macros.svh"

module binary_integral_image_core import bii_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    // pixel input
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [PIXEL_W-1:0]       s_pixel,
    // result output
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [AREA_W-1:0] m_area_sum,
    output logic                     m_last_of_frame
);

    // frame size, held as last column / last row index
    logic [COL_W-1:0] last_col_reg, last_col_next;
    logic [ROW_W-1:0] last_row_reg, last_row_next;

    // raster position and running row sum
    logic [COL_W-1:0]            col_reg, col_next;
    logic [ROW_W-1:0]            row_reg, row_next;
    logic signed [ROW_SUM_W-1:0] run_sum_reg, run_sum_next;

    // result register
    logic                     m_valid_reg, m_valid_next;
    logic signed [AREA_W-1:0] m_area_sum_reg, m_area_sum_next;
    logic                     m_last_reg, m_last_next;

    logic                     accept;
    logic signed [ROW_SUM_W-1:0] delta;
    logic signed [ROW_SUM_W-1:0] run_sum_new;
    logic signed [LINE_W-1:0] line_head;
    logic signed [LINE_W-1:0] above;
    logic signed [LINE_W-1:0] area_full;
    logic signed [AREA_W-1:0] area_shown;
    logic                     end_row;
    logic                     end_frame;
    line_ctrl_t               line_ctrl;

    // a new pixel is taken whenever the result register is free or drains now
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // pixel mapping and summed-area value
    assign delta       = (s_pixel == PIXEL_HIT) ? ROW_SUM_W'(1) : ROW_SUM_W'(-1);
    assign run_sum_new = run_sum_reg + delta;
    // first row sees zero above, whatever the chain holds
    assign above       = (row_reg == '0) ? '0 : line_head;
    assign area_full   = LINE_W'(run_sum_new) + above;

    assign end_row   = (col_reg >= last_col_reg);
    assign end_frame = end_row && (row_reg >= last_row_reg);

    // saturate to the output width when the line value can exceed it
    if (LINE_W > AREA_W) begin : g_sat
        logic all_same;
        assign all_same = (area_full[LINE_W-1:AREA_W-1] == '0) ||
                          (area_full[LINE_W-1:AREA_W-1] == '1);
        always_comb begin
            if (all_same) begin
                area_shown = area_full[AREA_W-1:0];
            end else if (area_full[LINE_W-1]) begin
                area_shown = {1'b1, {(AREA_W-1){1'b0}}};
            end else begin
                area_shown = {1'b0, {(AREA_W-1){1'b1}}};
            end
        end
    end else begin : g_ext
        assign area_shown = AREA_W'(area_full);
    end

    // the chain shifts once per accepted pixel; the new value enters at the row end
    assign line_ctrl.shift    = accept;
    assign line_ctrl.last_col = last_col_reg;

    bii_line u_line (
        .aclk        (aclk),
        .ctrl        (line_ctrl),
        .insert_data (area_full),
        .head        (line_head)
    );

    // position, row sum and configuration
    always_comb begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        run_sum_next  = run_sum_reg;

        if (accept) begin
            if (end_frame) begin
                col_next     = '0;
                row_next     = '0;
                run_sum_next = '0;
            end else if (end_row) begin
                col_next     = '0;
                row_next     = row_reg + 1'b1;
                run_sum_next = '0;
            end else begin
                col_next     = col_reg + 1'b1;
                run_sum_next = run_sum_new;
            end
        end

        // a size write restarts the frame
        if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  last_col_next = last_col_index(cfg_data);
                REG_FRAME_HEIGHT: last_row_next = last_row_index(cfg_data);
                default: ;
            endcase
            col_next     = '0;
            row_next     = '0;
            run_sum_next = '0;
        end
    end

    // result register: load on a transaction, clear when taken
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_area_sum_next = m_area_sum_reg;
        m_last_next     = m_last_reg;
        if (accept) begin
            m_valid_next    = 1'b1;
            m_area_sum_next = area_shown;
            m_last_next     = end_frame;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg <= last_col_index(CFG_WIDTH_RESET);
            last_row_reg <= last_row_index(CFG_HEIGHT_RESET);
            col_reg      <= '0;
            row_reg      <= '0;
            run_sum_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            run_sum_reg  <= run_sum_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        m_area_sum_reg <= m_area_sum_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_area_sum      = m_area_sum_reg;
    assign m_last_of_frame = m_last_reg;

    // position never runs past the configured frame
    `ASSERT_ALWAYS(a_col_in_frame, aclk, aresetn, col_reg <= last_col_reg,
        "column past frame width")
    `ASSERT_ALWAYS(a_row_in_frame, aclk, aresetn, row_reg <= last_row_reg,
        "row past frame height")
    // after the last pixel of a frame the next pixel is the origin
    `ASSERT_NEXT(a_frame_wrap, aclk, aresetn, accept && end_frame,
        col_reg == '0 && row_reg == '0 && run_sum_reg == '0,
        "frame did not restart at origin")
    // input is never held off while the receiver takes results
    `ASSERT_IMPLIES(a_no_bubble, aclk, aresetn, m_ready, s_ready,
        "input stalled with receiver ready")

endmodule

// File: test/tb_binary_integral_image_core.sv
// testbench of the binary integral image core: directed table, random frames, self-checking
`timescale 1ns / 1ps

module tb_binary_integral_image_core import bii_pkg::*;;

    localparam int SUM_MAX        = 2 ** (AREA_W - 1) - 1;
    localparam int SUM_MIN        = -(2 ** (AREA_W - 1));
    localparam int PIXEL_TARGET   = 1550;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_DIRECTED   = 24;

    // one expected result transaction
    typedef struct packed {
        logic signed [AREA_W-1:0] area;
        logic                     last;
    } area_result_t;

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        STEP_PIXEL,
        STEP_SET_WIDTH,
        STEP_SET_HEIGHT
    } step_kind_t;

    // typed = 1 means the row carries its own expected result
    typedef struct {
        step_kind_t       kind;
        logic [CFG_W-1:0] value;
        bit               typed;
        int               area;
        bit               last;
    } directed_step_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    cfg_reg_t                 cfg_index;
    logic [CFG_W-1:0]         cfg_data;
    logic                     s_valid;
    logic                     s_ready;
    logic [PIXEL_W-1:0]       s_pixel;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [AREA_W-1:0] m_area_sum;
    logic                     m_last_of_frame;

    // mirror of the block: sizes as written, line of integral values, row sum, position
    logic [CFG_W-1:0] cfg_width_q;
    logic [CFG_W-1:0] cfg_height_q;
    int               line_store [MAX_WIDTH];
    int               row_acc;
    int               col_pos;
    int               row_pos;

    area_result_t     expected_sums [$];
    area_result_t     checked_result;
    directed_step_t   directed_steps [NUM_DIRECTED];

    int  mismatch_count;
    int  pixels_sent;
    int  idle_cycles;
    bit  src_burst;
    bit  sink_burst;

    binary_integral_image_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel         (s_pixel),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_area_sum      (m_area_sum),
        .m_last_of_frame (m_last_of_frame)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // zero acts as one, anything above the maximum acts as the maximum
    function automatic int effective_size(input logic [CFG_W-1:0] v, input int max_size);
        if (v == '0) begin
            return 1;
        end else if (int'(v) > max_size) begin
            return max_size;
        end
        return int'(v);
    endfunction

    // advances the mirror by one pixel and returns the integral value it produces
    function automatic area_result_t integral_predict(input logic [PIXEL_W-1:0] pix);
        int           w;
        int           h;
        int           col;
        int           above;
        int           area;
        bit           end_row;
        bit           end_frame;
        area_result_t r;
        w   = effective_size(cfg_width_q, MAX_WIDTH);
        h   = effective_size(cfg_height_q, MAX_HEIGHT);
        col = (col_pos >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_pos;
        row_acc += (pix == PIXEL_HIT) ? 1 : -1;
        // the first row never looks at the line store
        above = (row_pos == 0) ? 0 : line_store[col];
        area  = row_acc + above;
        line_store[col] = area;
        end_row   = (col_pos + 1 >= w);
        end_frame = end_row && (row_pos + 1 >= h);
        if (end_frame) begin
            row_acc = 0;
            col_pos = 0;
            row_pos = 0;
        end else if (end_row) begin
            row_acc = 0;
            col_pos = 0;
            row_pos++;
        end else begin
            col_pos++;
        end
        // the output saturates, the line store keeps the exact value
        if (area > SUM_MAX) area = SUM_MAX;
        if (area < SUM_MIN) area = SUM_MIN;
        r.area = AREA_W'(area);
        r.last = end_frame;
        return r;
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        case ($urandom_range(0, 3))
            0, 1: begin
                return PIXEL_HIT;
            end
            2: begin
                return PIXEL_W'($urandom_range(0, 255));
            end
            default: begin
                // just below the hit value and the lowest value
                return $urandom_range(0, 1) ? 8'd254 : 8'd0;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want_v);
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want_v);
        mismatch_count++;
    endtask

    // drop valid and let every outstanding result drain before touching registers
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (expected_sums.size() != 0) @(negedge aclk);
        // covers the registered result, plus margin
        repeat (2) @(negedge aclk);
    endtask

    task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        settle_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_FRAME_WIDTH) begin
            cfg_width_q = val;
        end else begin
            cfg_height_q = val;
        end
        // any write restarts the frame; the line store keeps its contents
        row_acc = 0;
        col_pos = 0;
        row_pos = 0;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // one pixel transaction; drain = hold off until every expected result has come
    task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input bit typed,
                              input int want_area, input bit want_last, input bit drain);
        area_result_t predicted;
        area_result_t typed_result;
        int           gap;
        gap = src_burst ? 0 : $urandom_range(0, 16);
        if (drain || gap > 0) begin
            s_valid <= 1'b0;
            if (drain) begin
                while (expected_sums.size() != 0) @(negedge aclk);
            end
            // valid is always sampled low before it rises again, so it is never lowered and raised in one step
            repeat ((gap == 0) ? 1 : gap) @(negedge aclk);
        end
        predicted = integral_predict(pix);
        if (typed) begin
            typed_result.area = AREA_W'(want_area);
            typed_result.last = want_last;
            expected_sums.push_back(typed_result);
        end else begin
            expected_sums.push_back(predicted);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
        pixels_sent++;
    endtask

    // one random phase: new sizes, then whole frames plus a partial one, or part of a large one
    task automatic run_random_phase();
        int which;
        int kind;
        int w;
        int h;
        int frame_px;
        int n;
        which = $urandom_range(0, 3);
        kind  = $urandom_range(0, 9);
        case (kind)
            0: begin
                w = $urandom_range(0, 1);
                h = $urandom_range(0, 12);
            end
            1: begin
                w = $urandom_range(1025, 2047);
                h = $urandom_range(1, 3);
            end
            2: begin
                w = $urandom_range(1, 4);
                h = $urandom_range(0, 1) ? 1024 : $urandom_range(1025, 2047);
            end
            default: begin
                w = $urandom_range(1, 12);
                h = $urandom_range(1, 8);
            end
        endcase
        // sometimes only one of the two registers changes
        if (which != 1) cfg_write(REG_FRAME_WIDTH, CFG_W'(w));
        if (which != 0) cfg_write(REG_FRAME_HEIGHT, CFG_W'(h));
        src_burst  = ($urandom_range(0, 3) == 0);
        sink_burst = ($urandom_range(0, 3) == 0);
        frame_px = effective_size(cfg_width_q, MAX_WIDTH) *
                   effective_size(cfg_height_q, MAX_HEIGHT);
        if (frame_px > 200) begin
            n = $urandom_range(8, 40);
        end else begin
            n = $urandom_range(1, 3) * frame_px + $urandom_range(0, frame_px - 1);
        end
        repeat (n) begin
            send_pixel(random_pixel(), 1'b0, 0, 1'b0, $urandom_range(0, 39) == 0);
        end
    endtask

    // result side: stall a random number of cycles per transaction, then wait for it
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            int stall;
            stall = sink_burst ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    // compare every result transaction with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_sums.size() == 0) begin
                report_mismatch("result with nothing expected, area_sum",
                                int'(m_area_sum), 0);
            end else begin
                checked_result = expected_sums.pop_front();
                if (m_area_sum !== checked_result.area) begin
                    report_mismatch("area_sum", int'(m_area_sum), int'(checked_result.area));
                end
                if (m_last_of_frame !== checked_result.last) begin
                    report_mismatch("last_of_frame", int'(m_last_of_frame),
                                    int'(checked_result.last));
                end
            end
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = REG_FRAME_WIDTH;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_pixel        = '0;
        mismatch_count = 0;
        pixels_sent    = 0;
        idle_cycles    = 0;
        src_burst      = 1'b0;
        sink_burst     = 1'b0;

        // mirror starts at the reset sizes with everything cleared
        cfg_width_q  = CFG_WIDTH_RESET;
        cfg_height_q = CFG_HEIGHT_RESET;
        foreach (line_store[i]) line_store[i] = 0;
        row_acc = 0;
        col_pos = 0;
        row_pos = 0;

        directed_steps = '{
            // first row after reset at 640 x 480: plain running sum
            '{STEP_PIXEL,      11'd255,  1'b1,  1, 1'b0},
            '{STEP_PIXEL,      11'd255,  1'b1,  2, 1'b0},
            '{STEP_PIXEL,      11'd0,    1'b1,  1, 1'b0},
            '{STEP_PIXEL,      11'd254,  1'b1,  0, 1'b0},
            '{STEP_PIXEL,      11'd127,  1'b1, -1, 1'b0},
            '{STEP_PIXEL,      11'd128,  1'b1, -2, 1'b0},
            '{STEP_PIXEL,      11'd1,    1'b1, -3, 1'b0},
            // 1 x 1 frame: every pixel ends a frame
            '{STEP_SET_WIDTH,  11'd1,    1'b0,  0, 1'b0},
            '{STEP_SET_HEIGHT, 11'd1,    1'b0,  0, 1'b0},
            '{STEP_PIXEL,      11'd255,  1'b1,  1, 1'b1},
            '{STEP_PIXEL,      11'd0,    1'b1, -1, 1'b1},
            // zero sizes act as one
            '{STEP_SET_WIDTH,  11'd0,    1'b0,  0, 1'b0},
            '{STEP_SET_HEIGHT, 11'd0,    1'b0,  0, 1'b0},
            '{STEP_PIXEL,      11'd0,    1'b1, -1, 1'b1},
            // oversize acts as the maximum
            '{STEP_SET_WIDTH,  11'd2047, 1'b0,  0, 1'b0},
            '{STEP_SET_HEIGHT, 11'd2047, 1'b0,  0, 1'b0},
            '{STEP_PIXEL,      11'd0,    1'b1, -1, 1'b0},
            '{STEP_PIXEL,      11'd255,  1'b1,  0, 1'b0},
            // 2 x 2 frame: second row reads the line store, then wraps
            '{STEP_SET_WIDTH,  11'd2,    1'b0,  0, 1'b0},
            '{STEP_SET_HEIGHT, 11'd2,    1'b0,  0, 1'b0},
            '{STEP_PIXEL,      11'd255,  1'b0,  0, 1'b0},
            '{STEP_PIXEL,      11'd0,    1'b0,  0, 1'b0},
            '{STEP_PIXEL,      11'd0,    1'b0,  0, 1'b0},
            '{STEP_PIXEL,      11'd255,  1'b0,  0, 1'b0}
        };

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_steps[i]) begin
            case (directed_steps[i].kind)
                STEP_SET_WIDTH: begin
                    cfg_write(REG_FRAME_WIDTH, directed_steps[i].value);
                end
                STEP_SET_HEIGHT: begin
                    cfg_write(REG_FRAME_HEIGHT, directed_steps[i].value);
                end
                default: begin
                    send_pixel(directed_steps[i].value[PIXEL_W-1:0], directed_steps[i].typed,
                               directed_steps[i].area, directed_steps[i].last, 1'b0);
                end
            endcase
        end

        // full-width rows: the second row has to get back the whole first row
        cfg_write(REG_FRAME_WIDTH, 11'd1024);
        cfg_write(REG_FRAME_HEIGHT, 11'd2);
        repeat (MAX_WIDTH + $urandom_range(16, 64)) begin
            send_pixel(random_pixel(), 1'b0, 0, 1'b0, $urandom_range(0, 199) == 0);
        end

        // make sure the sender drains the pipe at least once mid-stream
        send_pixel(random_pixel(), 1'b0, 0, 1'b0, 1'b1);

        while (pixels_sent < PIXEL_TARGET) begin
            run_random_phase();
        end

        settle_idle();
        repeat (4) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bii_pkg.sv
hw/rtl/bii_cell.sv
hw/rtl/bii_line.sv
hw/rtl/binary_integral_image_core.sv
test/tb_binary_integral_image_core.sv
